// ===== design/cinms_pkg.sv =====
// Package for the case-insensitive name merge sort unit.
// Sizes, the comparator result type and the name store address function; no dependencies.
package cinms_pkg;
  localparam int MAX_ENTRIES = 256;
  localparam int NAME_BYTES  = 32;
  localparam int CHUNKS      = (NAME_BYTES + 7) / 8;
  localparam int LAST_BYTES  = NAME_BYTES - 8 * (CHUNKS - 1);
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int PTR_W       = CNT_W + 1;
  localparam int CHK_W       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int NS_DEPTH    = MAX_ENTRIES * CHUNKS;
  localparam int NS_AW       = $clog2(NS_DEPTH);

  typedef struct packed {
    logic decided;
    logic not_after;
  } cmp_res_t;

  function automatic logic [NS_AW-1:0] ns_addr(input logic [IDX_W-1:0] entry,
                                               input logic [CHK_W-1:0] pos);
    ns_addr = NS_AW'(NS_AW'(entry) * NS_AW'(CHUNKS) + NS_AW'(pos));
  endfunction
endpackage

// ===== design/cinms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cinms_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/cinms_cmp.sv =====
// Case-folded comparison of one eight-character chunk of two names.
// Depends on cinms_pkg.
module cinms_cmp (
  input  logic [63:0]          x,
  input  logic [63:0]          y,
  input  logic [3:0]           nbytes,
  output cinms_pkg::cmp_res_t  res
);
  import cinms_pkg::*;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  always_comb begin
    logic [7:0] cx;
    logic [7:0] cy;
    res = '0;
    for (int j = 0; j < 8; j++) begin
      cx = fold(x[8*j +: 8]);
      cy = fold(y[8*j +: 8]);
      if (!res.decided && (4'(j) < nbytes)) begin
        if (cx != cy) begin
          res.decided   = 1'b1;
          res.not_after = cx < cy;
        end else if (cx == 8'h00) begin
          res.decided   = 1'b1;
          res.not_after = 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/case_insensitive_name_merge_sort_unit.sv =====
// Top level: load, bottom-up merge sort over an index list, ranked read-out.
// Depends on cinms_pkg, cinms_ram, cinms_cmp.
//
//  channel | ports                                             | role
//  in      | in_valid in_stall in_command in_name_chunk ...    | load chunk / read rank
//  out     | out_valid out_stall out_sorted_index ...          | one result per transaction
//
// Loads and out-of-range reads answer from idle, valid reads via S_RD (order list read).
// A name ending early passes through S_FILL, which writes zeros to each missing chunk.
// The closing load starts the sort: each merged element is fetched from the order
// list, its name is compared chunk by chunk through the single name store read
// port, and each merged run is then copied back; in_stall stays high meanwhile.
// Synchronous active-low reset clears control state; memories are not cleared.
module case_insensitive_name_merge_sort_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_name_chunk,
  input  logic        in_last_entry,
  input  logic [7:0]  in_read_rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_sorted_index,
  output logic [8:0]  out_entry_count,
  output logic        out_read_valid,
  output logic        out_overflow
);
  import cinms_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0,  S_RD  = 4'd1,  S_FILL = 4'd2,  S_WID = 4'd3,
                         S_MRG  = 4'd4,  S_LA  = 4'd5,  S_LA2  = 4'd6,  S_LB  = 4'd7,
                         S_LB2  = 4'd8,  S_PICK = 4'd9, S_CA   = 4'd10, S_CA2 = 4'd11,
                         S_CB2  = 4'd12, S_CP  = 4'd13, S_CP2  = 4'd14;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CHK_W-1:0] pos_r, pos_nxt;
  logic             closed_r, closed_nxt;
  logic             ovf_r, ovf_nxt;
  logic             sort_pend_r, sort_pend_nxt;
  logic [IDX_W-1:0] fill_ent_r, fill_ent_nxt;
  logic [PTR_W-1:0] width_r, width_nxt, lo_r, lo_nxt, a_r, a_nxt, a_end_r, a_end_nxt;
  logic [PTR_W-1:0] b_r, b_nxt, b_end_r, b_end_nxt, c_r, c_nxt;
  logic [IDX_W-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic [CHK_W-1:0] k_r, k_nxt;
  logic             init_r, init_nxt;
  logic [63:0]      wa_r, wa_nxt;

  logic             ov_r, ov_nxt, orv_r, orv_nxt, oovf_r, oovf_nxt;
  logic [7:0]       oidx_r, oidx_nxt;
  logic [8:0]       ocnt_r, ocnt_nxt;

  logic             ns_we, ol_we, mb_we;
  logic [NS_AW-1:0] ns_waddr, ns_raddr;
  logic [63:0]      ns_wdata, ns_rdata;
  logic [IDX_W-1:0] ol_waddr, ol_raddr, ol_wdata, ol_rdata;
  logic [IDX_W-1:0] mb_waddr, mb_raddr, mb_wdata, mb_rdata;
  cmp_res_t         cres;
  logic [3:0]       nbytes;
  logic             accept;

  cinms_ram #(.W(64), .D(NS_DEPTH)) u_names (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(ns_wdata),
    .raddr(ns_raddr), .rdata(ns_rdata));
  cinms_ram #(.W(IDX_W), .D(MAX_ENTRIES)) u_order (
    .clk(clk), .we(ol_we), .waddr(ol_waddr), .wdata(ol_wdata),
    .raddr(ol_raddr), .rdata(ol_rdata));
  cinms_ram #(.W(IDX_W), .D(MAX_ENTRIES)) u_mbuf (
    .clk(clk), .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata),
    .raddr(mb_raddr), .rdata(mb_rdata));

  assign nbytes = (k_r == CHK_W'(CHUNKS - 1)) ? 4'(LAST_BYTES) : 4'd8;
  cinms_cmp u_cmp (.x(wa_r), .y(ns_rdata), .nbytes(nbytes), .res(cres));

  assign in_stall = !((state_r == S_IDLE) && (!ov_r || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [CNT_W-1:0] cnt0;
    logic             room, fin, take_a, take_b;
    logic [CHK_W:0]   pos1;
    logic [PTR_W:0]   two_w, be;
    state_nxt = state_r;    cnt_nxt = cnt_r;         pos_nxt = pos_r;
    closed_nxt = closed_r;  ovf_nxt = ovf_r;         sort_pend_nxt = sort_pend_r;
    fill_ent_nxt = fill_ent_r;  width_nxt = width_r; lo_nxt = lo_r;
    a_nxt = a_r;  a_end_nxt = a_end_r;  b_nxt = b_r;  b_end_nxt = b_end_r;  c_nxt = c_r;
    ia_nxt = ia_r;  ib_nxt = ib_r;  k_nxt = k_r;  init_nxt = init_r;  wa_nxt = wa_r;
    ov_nxt = ov_r && out_stall;
    oidx_nxt = oidx_r; ocnt_nxt = ocnt_r; orv_nxt = orv_r; oovf_nxt = oovf_r;
    ns_we = 1'b0; ns_waddr = '0; ns_wdata = '0; ns_raddr = '0;
    ol_we = 1'b0; ol_waddr = '0; ol_wdata = '0; ol_raddr = '0;
    mb_we = 1'b0; mb_waddr = '0; mb_wdata = '0; mb_raddr = '0;
    cnt0 = '0; room = 1'b0; fin = 1'b0; take_a = 1'b0; take_b = 1'b0;
    pos1 = '0; two_w = '0; be = '0;

    unique case (state_r)
      S_IDLE: begin
        ol_raddr = in_read_rank[IDX_W-1:0];
        if (accept) begin
          if (!in_command) begin
            cnt0    = closed_r ? '0 : cnt_r;
            pos_nxt = closed_r ? '0 : pos_r;
            ovf_nxt = closed_r ? 1'b0 : ovf_r;
            closed_nxt = 1'b0;
            room = cnt0 < CNT_W'(MAX_ENTRIES);
            cnt_nxt = cnt0;
            ns_waddr = ns_addr(cnt0[IDX_W-1:0], pos_nxt);
            ns_wdata = in_name_chunk;
            ns_we = room;
            if (!room) ovf_nxt = 1'b1;
            pos1 = (CHK_W+1)'(pos_nxt) + 1'b1;
            fin = (pos1 == (CHK_W+1)'(CHUNKS)) || in_last_entry;
            if (fin) begin
              if (room) begin
                ol_we = 1'b1;
                ol_waddr = cnt0[IDX_W-1:0];
                ol_wdata = cnt0[IDX_W-1:0];
                cnt_nxt = cnt0 + 1'b1;
                if (pos1 != (CHK_W+1)'(CHUNKS)) begin
                  fill_ent_nxt = cnt0[IDX_W-1:0];
                  k_nxt = pos1[CHK_W-1:0];
                  state_nxt = S_FILL;
                end
              end
              pos_nxt = '0;
            end else begin
              pos_nxt = pos1[CHK_W-1:0];
            end
            sort_pend_nxt = in_last_entry;
            if (in_last_entry && state_nxt == S_IDLE) begin
              width_nxt = PTR_W'(1);
              state_nxt = S_WID;
            end
            ov_nxt = 1'b1; oidx_nxt = '0; orv_nxt = 1'b0;
            ocnt_nxt = 9'(cnt_nxt); oovf_nxt = ovf_nxt;
          end else if (closed_r && (32'(in_read_rank) < 32'(cnt_r))) begin
            state_nxt = S_RD;
          end else begin
            ov_nxt = 1'b1; oidx_nxt = '0; orv_nxt = 1'b0;
            ocnt_nxt = 9'(cnt_r); oovf_nxt = ovf_r;
          end
        end
      end
      S_RD: begin
        ov_nxt = 1'b1; oidx_nxt = 8'(ol_rdata); orv_nxt = 1'b1;
        ocnt_nxt = 9'(cnt_r); oovf_nxt = ovf_r;
        state_nxt = S_IDLE;
      end
      S_FILL: begin
        ns_we = 1'b1;
        ns_waddr = ns_addr(fill_ent_r, k_r);
        if (k_r == CHK_W'(CHUNKS - 1)) begin
          if (sort_pend_r) begin
            width_nxt = PTR_W'(1);
            state_nxt = S_WID;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_WID: begin
        if (width_r >= PTR_W'(cnt_r)) begin
          closed_nxt = 1'b1;
          sort_pend_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          lo_nxt = '0;
          state_nxt = S_MRG;
        end
      end
      S_MRG: begin
        two_w = (PTR_W+1)'(width_r) << 1;
        if ((PTR_W+1)'(lo_r) + (PTR_W+1)'(width_r) >= (PTR_W+1)'(cnt_r)) begin
          width_nxt = two_w[PTR_W-1:0];
          state_nxt = S_WID;
        end else begin
          be = (PTR_W+1)'(lo_r) + two_w;
          a_nxt = lo_r;
          a_end_nxt = lo_r + width_r;
          b_nxt = lo_r + width_r;
          b_end_nxt = (be > (PTR_W+1)'(cnt_r)) ? PTR_W'(cnt_r) : be[PTR_W-1:0];
          c_nxt = lo_r;
          init_nxt = 1'b1;
          state_nxt = S_LA;
        end
      end
      S_LA: begin
        ol_raddr = a_r[IDX_W-1:0];
        state_nxt = S_LA2;
      end
      S_LA2: begin
        ia_nxt = ol_rdata;
        state_nxt = init_r ? S_LB : S_PICK;
      end
      S_LB: begin
        ol_raddr = b_r[IDX_W-1:0];
        state_nxt = S_LB2;
      end
      S_LB2: begin
        ib_nxt = ol_rdata;
        init_nxt = 1'b0;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (a_r < a_end_r && b_r < b_end_r) begin
          k_nxt = '0;
          state_nxt = S_CA;
        end else if (a_r < a_end_r) begin
          take_a = 1'b1;
        end else if (b_r < b_end_r) begin
          take_b = 1'b1;
        end else begin
          c_nxt = lo_r;
          state_nxt = S_CP;
        end
      end
      S_CA: begin
        ns_raddr = ns_addr(ia_r, k_r);
        state_nxt = S_CA2;
      end
      S_CA2: begin
        wa_nxt = ns_rdata;
        ns_raddr = ns_addr(ib_r, k_r);
        state_nxt = S_CB2;
      end
      S_CB2: begin
        if (cres.decided || k_r == CHK_W'(CHUNKS - 1)) begin
          take_a = !cres.decided || cres.not_after;
          take_b = !take_a;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_CA;
        end
      end
      S_CP: begin
        mb_raddr = c_r[IDX_W-1:0];
        state_nxt = S_CP2;
      end
      S_CP2: begin
        ol_we = 1'b1;
        ol_waddr = c_r[IDX_W-1:0];
        ol_wdata = mb_rdata;
        c_nxt = c_r + 1'b1;
        if (c_r + 1'b1 < b_end_r) begin
          state_nxt = S_CP;
        end else begin
          lo_nxt = lo_r + (width_r << 1);
          state_nxt = S_MRG;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (take_a) begin
      mb_we = 1'b1; mb_waddr = c_r[IDX_W-1:0]; mb_wdata = ia_r;
      c_nxt = c_r + 1'b1; a_nxt = a_r + 1'b1;
      state_nxt = (a_r + 1'b1 < a_end_r) ? S_LA : S_PICK;
    end else if (take_b) begin
      mb_we = 1'b1; mb_waddr = c_r[IDX_W-1:0]; mb_wdata = ib_r;
      c_nxt = c_r + 1'b1; b_nxt = b_r + 1'b1;
      state_nxt = (b_r + 1'b1 < b_end_r) ? S_LB : S_PICK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  cnt_r <= '0;  pos_r <= '0;  closed_r <= 1'b0;
      ovf_r <= 1'b0;  sort_pend_r <= 1'b0;  ov_r <= 1'b0;  init_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  cnt_r <= cnt_nxt;  pos_r <= pos_nxt;  closed_r <= closed_nxt;
      ovf_r <= ovf_nxt;  sort_pend_r <= sort_pend_nxt;  ov_r <= ov_nxt;  init_r <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_ent_r <= fill_ent_nxt;  width_r <= width_nxt;  lo_r <= lo_nxt;
    a_r <= a_nxt;  a_end_r <= a_end_nxt;  b_r <= b_nxt;  b_end_r <= b_end_nxt;
    c_r <= c_nxt;  ia_r <= ia_nxt;  ib_r <= ib_nxt;  k_r <= k_nxt;  wa_r <= wa_nxt;
    oidx_r <= oidx_nxt;  ocnt_r <= ocnt_nxt;  orv_r <= orv_nxt;  oovf_r <= oovf_nxt;
  end

  assign out_valid        = ov_r;
  assign out_sorted_index = oidx_r;
  assign out_entry_count  = ocnt_r;
  assign out_read_valid   = orv_r;
  assign out_overflow     = oovf_r;

`ifndef NO_ASSERTIONS
  a_rd_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> !ov_r) else $error("read result would overwrite pending result");
  a_rd_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> ov_r && orv_r) else $error("valid read produced no result");
  a_open_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_RD) |-> !closed_r)
    else $error("set closed while sort in progress");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES)) else $error("entry count beyond capacity");
`endif
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for case_insensitive_name_merge_sort_unit.
// Loads name sets, reads back sorted ranks and checks each result against a
// local stable merge sort predictor. Depends on cinms_pkg and the unit's RTL.
`timescale 1ns / 1ps
module testbench;
  import cinms_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct {
    logic [7:0] idx;
    logic [8:0] cnt;
    logic       rv;
    logic       ovf;
  } sort_result_t;

  typedef struct {
    logic        cmd;
    logic [63:0] chunk;
    logic        last;
    logic [7:0]  rank;
    logic        typed;
    logic [7:0]  e_idx;
    logic [8:0]  e_cnt;
    logic        e_rv;
    logic        e_ovf;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_command, in_last_entry;
  logic [63:0] in_name_chunk;
  logic [7:0] in_read_rank;
  logic out_valid, out_stall, out_read_valid, out_overflow;
  logic [7:0] out_sorted_index;
  logic [8:0] out_entry_count;

  case_insensitive_name_merge_sort_unit uut (.*);

  // predictor state
  logic [63:0] names [MAX_ENTRIES][CHUNKS];
  int ranked [MAX_ENTRIES];
  int n_names, chunk_pos;
  bit closed, ovf_seen;

  sort_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;

  function automatic int fold_char(int e, int p);
    int c;
    c = int'((names[e][p/8] >> ((p % 8) * 8)) & 64'hFF);
    if (c >= 8'h61 && c <= 8'h7A) c -= 8'h20;
    return c;
  endfunction

  function automatic bit sorts_not_after(int x, int y);
    int cx, cy;
    for (int k = 0; k < NAME_BYTES; k++) begin
      cx = fold_char(x, k);
      cy = fold_char(y, k);
      if (cx != cy) return cx < cy;
      if (cx == 0) return 1;
    end
    return 1;
  endfunction

  function automatic void sort_names();
    int tmp [MAX_ENTRIES];
    int a, ae, b, be, c;
    for (int w = 1; w < n_names; w *= 2)
      for (int lo = 0; lo + w < n_names; lo += 2 * w) begin
        a = lo; ae = lo + w; b = ae; be = lo + 2 * w; c = lo;
        if (be > n_names) be = n_names;
        while (a < ae || b < be) begin
          if (b >= be || (a < ae && sorts_not_after(ranked[a], ranked[b]))) begin
            tmp[c] = ranked[a]; a++;
          end else begin
            tmp[c] = ranked[b]; b++;
          end
          c++;
        end
        for (int i = lo; i < be; i++) ranked[i] = tmp[i];
      end
  endfunction

  function automatic sort_result_t predict_sort(logic cmd, logic [63:0] chunk,
                                                logic last, logic [7:0] rank);
    sort_result_t r;
    bit room;
    r.idx = 0; r.rv = 0;
    if (cmd == CMD_LOAD) begin
      if (closed) begin
        n_names = 0; chunk_pos = 0; ovf_seen = 0; closed = 0;
      end
      room = n_names < MAX_ENTRIES;
      if (room) names[n_names][chunk_pos] = chunk;
      else ovf_seen = 1;
      chunk_pos++;
      if (chunk_pos >= CHUNKS || last) begin
        if (room) begin
          while (chunk_pos < CHUNKS) begin
            names[n_names][chunk_pos] = 0;
            chunk_pos++;
          end
          ranked[n_names] = n_names;
          n_names++;
        end
        chunk_pos = 0;
      end
      if (last) begin
        sort_names();
        closed = 1;
      end
    end else if (closed && rank < n_names) begin
      r.idx = ranked[rank][7:0];
      r.rv = 1;
    end
    r.cnt = n_names[8:0];
    r.ovf = ovf_seen;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    sort_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction idx=%0d cnt=%0d", $time,
                 out_sorted_index, out_entry_count);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_sorted_index !== e.idx || out_entry_count !== e.cnt ||
            out_read_valid !== e.rv || out_overflow !== e.ovf) begin
          $display("%0t: mismatch expected idx=%0d cnt=%0d rv=%0b ovf=%0b, %s",
                   $time, e.idx, e.cnt, e.rv, e.ovf, "got");
          $display("%0t:   got idx=%0d cnt=%0d rv=%0b ovf=%0b", $time,
                   out_sorted_index, out_entry_count, out_read_valid, out_overflow);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  int burst_left = 0;

  task automatic send_item(logic cmd, logic [63:0] chunk, logic last, logic [7:0] rank,
                           output sort_result_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_name_chunk <= chunk;
    in_last_entry <= last;
    in_read_rank <= rank;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_sort(cmd, chunk, last, rank);
    expected_q.push_back(r);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_chunk(int style);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (style == 0) begin
      // letters of mixed case from a small alphabet, sometimes a NUL
      for (int i = 0; i < 8; i++) begin
        v[i*8 +: 8] = 8'(8'h41 + $urandom_range(0, 2) +
                         ($urandom_range(0, 1) ? 8'h20 : 8'h00));
        if ($urandom_range(0, 15) == 0) v[i*8 +: 8] = 8'h00;
      end
    end
    return v;
  endfunction

  task automatic load_set(int n, int style, bit early);
    sort_result_t r;
    int nch;
    for (int e = 0; e < n; e++) begin
      nch = early && $urandom_range(0, 2) == 0 ? $urandom_range(1, CHUNKS) : CHUNKS;
      if (e == n - 1 && early) nch = $urandom_range(1, CHUNKS);
      for (int c = 0; c < nch; c++)
        send_item(CMD_LOAD, rand_chunk(style), (e == n - 1) && (c == nch - 1),
                  8'($urandom), r);
    end
  endtask

  task automatic read_set(int reads);
    sort_result_t r;
    for (int i = 0; i < reads; i++)
      send_item(CMD_READ, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, n_names)), r);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(logic cmd, logic [63:0] ch, logic last, logic [7:0] rk,
                                    logic typed, logic [7:0] ei, logic [8:0] ec,
                                    logic ev, logic eo);
    stim_row_t s;
    s.cmd = cmd; s.chunk = ch; s.last = last; s.rank = rk; s.typed = typed;
    s.e_idx = ei; s.e_cnt = ec; s.e_rv = ev; s.e_ovf = eo;
    return s;
  endfunction

  initial begin
    sort_result_t r;
    n_names = 0; chunk_pos = 0; closed = 0; ovf_seen = 0;
    rst_n = 0; in_valid = 0; in_command = 0; in_name_chunk = 0;
    in_last_entry = 0; in_read_rank = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: read before close, names in lower and upper case, early end,
    // no-NUL names, extreme chunks, rank too high
    dir_rows.push_back(row(CMD_READ, '0, 0, 8'd0, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ, '1, 1, 8'd255, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, 64'h0000_0000_0062_6F62, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, '0, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, 64'h0000_0000_0042_4F41, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, '1, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, '1, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, '1, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, '1, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, '0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, 64'h0000_0000_0042_4F42, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, 64'h7A7A_7A7A_7A7A_7A7A, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ, '0, 0, 8'd0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ, '0, 0, 8'd1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ, '0, 0, 8'd2, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ, '0, 0, 8'd3, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ, '1, 1, 8'd255, 1, 0, 9'd2, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, '0, 1, 0, 1, 0, 9'd1, 0, 0));
    dir_rows.push_back(row(CMD_READ, '0, 0, 8'd0, 1, 0, 9'd1, 1, 0));
    dir_rows.push_back(row(CMD_READ, '0, 0, 8'd1, 1, 0, 9'd1, 0, 0));
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].chunk, dir_rows[i].last, dir_rows[i].rank, r);
      if (dir_rows[i].typed && (r.idx !== dir_rows[i].e_idx || r.cnt !== dir_rows[i].e_cnt ||
          r.rv !== dir_rows[i].e_rv || r.ovf !== dir_rows[i].e_ovf)) begin
        $display("%0t: table row %0d expected idx=%0d cnt=%0d rv=%0b ovf=%0b", $time, i,
                 dir_rows[i].e_idx, dir_rows[i].e_cnt, dir_rows[i].e_rv, dir_rows[i].e_ovf);
        $display("%0t:   got idx=%0d cnt=%0d rv=%0b ovf=%0b", $time,
                 r.idx, r.cnt, r.rv, r.ovf);
        errors++;
      end
    end
    drain();

    // random sets, mostly small
    for (int s = 0; s < 6; s++) begin
      load_set($urandom_range(1, 12), $urandom_range(0, 3) != 0 ? 0 : 1,
               1'($urandom_range(0, 1)));
      read_set($urandom_range(4, 14));
      if (s % 3 == 2) drain();
    end

    // full set overflowed by two names, rank 255 included
    drain();
    load_set(MAX_ENTRIES + 2, 0, 1);
    read_set(10);
    send_item(CMD_READ, '0, 0, 8'd255, r);
    load_set($urandom_range(2, 6), 0, 0);
    read_set(8);

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== case_insensitive_name_merge_sort_unit.f =====
design/cinms_pkg.sv
design/cinms_ram.sv
design/cinms_cmp.sv
design/case_insensitive_name_merge_sort_unit.sv
tb/sv/testbench.sv
